>>> src/cfts_pkg.sv
package cfts_pkg;

	localparam int WORD_W        = 64;
	localparam int COUNT_W       = 12;
	localparam int THR_W         = 17;
	localparam int PCNT_W        = 3;
	localparam int POP_W         = $clog2(WORD_W + 1);
	localparam int NUM_PARTS     = 4;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = THR_W;
	localparam int FRAC_W        = 16;
	localparam int DEF_FP_WORDS  = 32;
	localparam int DEF_MAX_PARTS = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 1'b0,
		REG_PART_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] common_cnt;
		logic [COUNT_W-1:0] union_cnt;
	} totals_t;

	// adder tree, six levels deep
	function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] w);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int i = 0; i < 32; i++) begin
			l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		end
		return {1'b0, l5[0]} + {1'b0, l5[1]};
	endfunction

endpackage

>>> src/cfts_if.sv
interface cfts_word_if;
	import cfts_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] part_word_0;
	logic [WORD_W-1:0] part_word_1;
	logic [WORD_W-1:0] part_word_2;
	logic [WORD_W-1:0] part_word_3;
	logic [WORD_W-1:0] add_word;
	logic [WORD_W-1:0] keep_word;
	logic [WORD_W-1:0] query_word;
	logic              last_word;

	modport source (
		output valid, part_word_0, part_word_1, part_word_2, part_word_3,
		       add_word, keep_word, query_word, last_word,
		input  ready
	);
	modport sink (
		input  valid, part_word_0, part_word_1, part_word_2, part_word_3,
		       add_word, keep_word, query_word, last_word,
		output ready
	);
endinterface

interface cfts_score_if;
	import cfts_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] common_bits;
	logic [COUNT_W-1:0] union_bits;
	logic               passes;

	modport source (output valid, common_bits, union_bits, passes, input ready);
	modport sink (input valid, common_bits, union_bits, passes, output ready);
endinterface

>>> src/combined_fingerprint_tanimoto_screen_core.sv
// channel  | modport | role
// words    | sink    | one fingerprint word per request, last_word closes a fingerprint
// scores   | source  | one request per fingerprint: counts and pass flag
// cfg      | write   | cfg_we / cfg_index / cfg_data, no read-back
//
// one word per cycle sustained, unless a stalled score holds a last word back
// stages: input register, popcount and accumulate, multiply-compare into output register
// reset clears threshold to 0, part_count to 1 and both running counts
// a stalled score holds back only last words and the words queued behind them
module combined_fingerprint_tanimoto_screen_core #(
	parameter int FP_WORDS  = cfts_pkg::DEF_FP_WORDS,
	parameter int MAX_PARTS = cfts_pkg::DEF_MAX_PARTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfts_pkg::CFG_DATA_W-1:0] cfg_data,
	cfts_word_if.sink                       words,
	cfts_score_if.source                    scores
);
	import cfts_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [PCNT_W-1:0] pcnt_q;

	logic [WORD_W-1:0] parts [NUM_PARTS];
	logic [WORD_W-1:0] comb_word;

	logic              valid_s1;
	logic              last_s1;
	logic [WORD_W-1:0] comb_s1;
	logic [WORD_W-1:0] query_s1;

	logic              valid_s2;
	totals_t           totals_s2;
	totals_t           totals;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_common_q;
	logic [COUNT_W-1:0] out_union_q;
	logic               out_pass_q;

	logic out_free, s2_ready, s2_move, s1_move, s1_ready, accept;
	logic [THR_W+COUNT_W-1:0] prod;
	logic [THR_W+COUNT_W-1:0] scaled;
	logic                     pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			pcnt_q <= PCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:  thr_q  <= cfg_data[THR_W-1:0];
				REG_PART_COUNT: pcnt_q <= cfg_data[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake between stages; only last words go past stage one
	assign out_free = !out_valid_q || scores.ready;
	assign s2_move  = valid_s2 && out_free;
	assign s2_ready = !valid_s2 || out_free;
	assign s1_move  = valid_s1 && (!last_s1 || s2_ready);
	assign s1_ready = !valid_s1 || s1_move;
	assign accept   = words.valid && s1_ready;
	assign words.ready = s1_ready;

	assign parts[0] = words.part_word_0;
	assign parts[1] = words.part_word_1;
	assign parts[2] = words.part_word_2;
	assign parts[3] = words.part_word_3;

	// part zero always used, others up to part_count and the build limit; add_word ORed in, keep_word masks
	always_comb begin
		comb_word = words.add_word;
		for (int i = 0; i < NUM_PARTS; i++) begin
			if (i < MAX_PARTS && (i == 0 || PCNT_W'(i) < pcnt_q)) begin
				comb_word = comb_word | parts[i];
			end
		end
		comb_word = comb_word & words.keep_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			comb_s1  <= comb_word;
			query_s1 <= words.query_word;
			last_s1  <= words.last_word;
		end
	end

	cfts_word_count #(
		.FP_WORDS (FP_WORDS)
	) u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_move),
		.last       (last_s1),
		.comb_word  (comb_s1),
		.query_word (query_s1),
		.totals     (totals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			totals_s2 <= totals;
		end
	end

	// common * 2^16 >= threshold * union, empty union passes only at zero threshold
	always_comb begin
		prod   = (THR_W + COUNT_W)'(thr_q) * (THR_W + COUNT_W)'(totals_s2.union_cnt);
		scaled = (THR_W + COUNT_W)'({totals_s2.common_cnt, FRAC_W'(0)});
		if (totals_s2.union_cnt == '0) begin
			pass = (thr_q == '0);
		end else begin
			pass = (scaled >= prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (scores.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_common_q <= totals_s2.common_cnt;
			out_union_q  <= totals_s2.union_cnt;
			out_pass_q   <= pass;
		end
	end

	assign scores.valid       = out_valid_q;
	assign scores.common_bits = out_common_q;
	assign scores.union_bits  = out_union_q;
	assign scores.passes      = out_pass_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> valid_s1 && last_s1 && valid_s2)
		else $error("input stalled without a held last word");
	a_score_order: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid |-> scores.common_bits <= scores.union_bits)
		else $error("score intersection exceeds union");
	a_zero_common_fails: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid && scores.passes && scores.union_bits != '0 |->
			scores.common_bits != '0 || thr_q == '0)
		else $error("empty intersection passed a nonzero threshold");
	a_s2_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(last_s1))
		else $error("non-last word reached the score stage");
`endif

endmodule

>>> src/cfts_word_count.sv
module cfts_word_count #(
	parameter int FP_WORDS = cfts_pkg::DEF_FP_WORDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        last,
	input  logic [cfts_pkg::WORD_W-1:0] comb_word,
	input  logic [cfts_pkg::WORD_W-1:0] query_word,
	output cfts_pkg::totals_t           totals
);
	import cfts_pkg::*;

	localparam int LIMIT_I = (FP_WORDS * WORD_W > 4095) ? 4095 : FP_WORDS * WORD_W;
	localparam logic [COUNT_W:0] LIMIT = (COUNT_W + 1)'(LIMIT_I);

	logic [COUNT_W-1:0] common_q;
	logic [COUNT_W-1:0] union_q;
	logic [COUNT_W:0]   common_sum;
	logic [COUNT_W:0]   union_sum;

	always_comb begin
		common_sum = {1'b0, common_q} + (COUNT_W + 1)'(popcount64(comb_word & query_word));
		union_sum  = {1'b0, union_q} + (COUNT_W + 1)'(popcount64(comb_word | query_word));
		// saturate on an overlong stream
		totals.common_cnt = (common_sum > LIMIT) ? LIMIT[COUNT_W-1:0] : common_sum[COUNT_W-1:0];
		totals.union_cnt  = (union_sum > LIMIT) ? LIMIT[COUNT_W-1:0] : union_sum[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_q <= '0;
			union_q  <= '0;
		end else if (step) begin
			if (last) begin
				common_q <= '0;
				union_q  <= '0;
			end else begin
				common_q <= totals.common_cnt;
				union_q  <= totals.union_cnt;
			end
		end
	end

`ifndef SYNTHESIS
	a_common_le_union: assert property (@(posedge clk) disable iff (!arst_n)
		common_q <= union_q)
		else $error("intersection count exceeds union count");
	a_union_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, union_q} <= LIMIT)
		else $error("union count above saturation limit");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> common_q == '0 && union_q == '0)
		else $error("counters not cleared after last word");
`endif

endmodule

>>> dv/combined_fingerprint_tanimoto_screen_core_tb.sv
`timescale 1ns / 100ps

localparam int COUNT_CAP = (cfts_pkg::DEF_FP_WORDS * 64 > 4095) ? 4095
	: cfts_pkg::DEF_FP_WORDS * 64;

typedef struct {
	bit [cfts_pkg::WORD_W-1:0] part [cfts_pkg::NUM_PARTS];
	bit [cfts_pkg::WORD_W-1:0] add;
	bit [cfts_pkg::WORD_W-1:0] keep;
	bit [cfts_pkg::WORD_W-1:0] query;
	bit                        last;
} word_item_t;

typedef struct packed {
	bit [cfts_pkg::COUNT_W-1:0] common_bits;
	bit [cfts_pkg::COUNT_W-1:0] union_bits;
	bit                         passes;
} score_t;

class tanimoto_tracker;
	bit [cfts_pkg::THR_W-1:0]  thr;
	bit [cfts_pkg::PCNT_W-1:0] parts;
	int                        common_run;
	int                        union_run;
	score_t                    pending_scores[$];
	int                        fails;
	int                        checked;
	int                        passing;
	int                        saturated;

	function new();
		thr = '0;
		parts = 1;
		common_run = 0;
		union_run = 0;
		fails = 0;
		checked = 0;
		passing = 0;
		saturated = 0;
	endfunction

	function void load_reg(cfts_pkg::cfg_reg_t idx, bit [cfts_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			cfts_pkg::REG_THRESHOLD: thr = val[cfts_pkg::THR_W-1:0];
			cfts_pkg::REG_PART_COUNT: parts = val[cfts_pkg::PCNT_W-1:0];
			default: ;
		endcase
	endfunction

	function int add_capped(int acc, int n);
		return (acc + n > COUNT_CAP) ? COUNT_CAP : acc + n;
	endfunction

	function void note_word(word_item_t w);
		int                        used;
		bit [cfts_pkg::WORD_W-1:0] comb;
		bit [63:0]                 lhs;
		bit [63:0]                 rhs;
		score_t                    s;
		used = (parts == 0) ? 1 : (parts > cfts_pkg::DEF_MAX_PARTS) ?
			cfts_pkg::DEF_MAX_PARTS : int'(parts);
		comb = '0;
		for (int i = 0; i < used; i++)
			comb |= w.part[i];
		comb = (comb | w.add) & w.keep;
		common_run = add_capped(common_run, $countones(comb & w.query));
		union_run = add_capped(union_run, $countones(comb | w.query));
		if (w.last) begin
			lhs = 64'(common_run) << 16;
			rhs = 64'(thr) * 64'(union_run);
			s.common_bits = common_run[cfts_pkg::COUNT_W-1:0];
			s.union_bits = union_run[cfts_pkg::COUNT_W-1:0];
			// empty union passes only on a zero threshold
			s.passes = (union_run == 0) ? (thr == 0) : (lhs >= rhs);
			pending_scores = {pending_scores, s};
			common_run = 0;
			union_run = 0;
		end
	endfunction

	function void check_score(score_t got);
		score_t want;
		if (pending_scores.size() == 0) begin
			$error("score with no fingerprint pending: common_bits %0d union_bits %0d passes %0d",
				got.common_bits, got.union_bits, got.passes);
			fails++;
		end else begin
			want = pending_scores.pop_front();
			checked++;
			if (want.passes)
				passing++;
			if (want.union_bits == COUNT_CAP)
				saturated++;
			if (got.common_bits !== want.common_bits) begin
				$error("common_bits: expected %0d, actual %0d", want.common_bits, got.common_bits);
				fails++;
			end
			if (got.union_bits !== want.union_bits) begin
				$error("union_bits: expected %0d, actual %0d", want.union_bits, got.union_bits);
				fails++;
			end
			if (got.passes !== want.passes) begin
				$error("passes: expected %0d, actual %0d", want.passes, got.passes);
				fails++;
			end
		end
	endfunction
endclass

module combined_fingerprint_tanimoto_screen_core_tb;
	import cfts_pkg::*;

	localparam bit [WORD_W-1:0] ONES = '1;
	localparam bit [WORD_W-1:0] LOW32 = 64'h0000_0000_FFFF_FFFF;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_WORDS = 135;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfts_word_if  words_ch ();
	cfts_score_if scores_ch ();

	tanimoto_tracker tally;
	int              rx_level;
	int              rdy_hold;
	logic            rdy_val;
	int              quiet_cycles;
	int              words_sent;
	int              prints_sent;
	int              settings_used;

	combined_fingerprint_tanimoto_screen_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.words    (words_ch),
		.scores   (scores_ch)
	);

	always #4 clk = ~clk;

	// score receiver: always ready at level zero, else random ready, occasionally a long stall
	always @(negedge clk) begin
		if (rdy_hold == 0) begin
			if (rx_level == 0) begin
				rdy_val = 1'b1;
				rdy_hold = 1;
			end else begin
				rdy_val = ($urandom_range(0, 3) != 0);
				if (rdy_val)
					rdy_hold = $urandom_range(1, 8);
				else if ($urandom_range(0, 15) == 0)
					rdy_hold = $urandom_range(20, 60);
				else
					rdy_hold = $urandom_range(1, 3);
			end
		end
		scores_ch.ready <= rdy_val;
		rdy_hold--;
	end

	always @(posedge clk) begin
		if (arst_n && scores_ch.valid && scores_ch.ready)
			tally.check_score('{scores_ch.common_bits, scores_ch.union_bits, scores_ch.passes});
	end

	always @(posedge clk) begin
		if (!arst_n || (words_ch.valid && words_ch.ready) || (scores_ch.valid && scores_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int pick_gap(int level);
		int r;
		if (level == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit [WORD_W-1:0] rand_bits(int density);
		case (density)
			0: return '0;
			1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2: return {$urandom, $urandom};
			3: return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
			default: return ONES;
		endcase
	endfunction

	task automatic send_word(input word_item_t w, input int gap);
		repeat (gap) begin
			@(negedge clk);
			words_ch.valid <= 1'b0;
		end
		@(negedge clk);
		words_ch.valid <= 1'b1;
		words_ch.part_word_0 <= w.part[0];
		words_ch.part_word_1 <= w.part[1];
		words_ch.part_word_2 <= w.part[2];
		words_ch.part_word_3 <= w.part[3];
		words_ch.add_word <= w.add;
		words_ch.keep_word <= w.keep;
		words_ch.query_word <= w.query;
		words_ch.last_word <= w.last;
		@(posedge clk);
		while (!words_ch.ready)
			@(posedge clk);
		tally.note_word(w);
		words_sent++;
		if (w.last)
			prints_sent++;
	endtask

	task automatic send_fields(input bit [WORD_W-1:0] p0, p1, p2, p3, add, keep, query,
		input bit last);
		word_item_t w;
		w.part[0] = p0;
		w.part[1] = p1;
		w.part[2] = p2;
		w.part[3] = p3;
		w.add = add;
		w.keep = keep;
		w.query = query;
		w.last = last;
		send_word(w, 0);
	endtask

	// stop sending, wait for every score, then let the pipeline empty out
	task automatic settle_block();
		@(negedge clk);
		words_ch.valid <= 1'b0;
		while (tally.pending_scores.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input bit [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tally.load_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_screen(input bit [CFG_DATA_W-1:0] thr, input bit [CFG_DATA_W-1:0] pc);
		settle_block();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_PART_COUNT, pc);
		settings_used++;
	endtask

	task automatic send_fingerprint(input int n_words, input bit overlong, input int tx_level);
		word_item_t w;
		int         d_part [NUM_PARTS];
		int         d_add;
		int         d_keep;
		int         q_mode;
		for (int i = 0; i < NUM_PARTS; i++)
			d_part[i] = ($urandom_range(0, 9) == 0) ? 4 * $urandom_range(0, 1)
				: $urandom_range(1, 3);
		d_add = $urandom_range(0, 2);
		d_keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 4);
		q_mode = $urandom_range(0, 2);
		for (int k = 0; k < n_words; k++) begin
			for (int i = 0; i < NUM_PARTS; i++)
				w.part[i] = overlong ? ONES : rand_bits(d_part[i]);
			w.add = overlong ? '0 : rand_bits(d_add);
			w.keep = overlong ? ONES : rand_bits(d_keep);
			// a query close to the combined word gives high similarity
			if (overlong)
				w.query = ONES;
			else if (q_mode == 0)
				w.query = (w.part[0] | w.add) ^ rand_bits(1);
			else
				w.query = rand_bits($urandom_range(0, 4));
			w.last = (k == n_words - 1);
			send_word(w, pick_gap(tx_level));
		end
	endtask

	initial begin
		int                    phase_words;
		int                    fp;
		int                    pause_at;
		int                    n;
		bit                    overlong;
		bit [CFG_DATA_W-1:0]   thr;
		tally = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		words_ch.valid = 1'b0;
		words_ch.part_word_0 = '0;
		words_ch.part_word_1 = '0;
		words_ch.part_word_2 = '0;
		words_ch.part_word_3 = '0;
		words_ch.add_word = '0;
		words_ch.keep_word = '0;
		words_ch.query_word = '0;
		words_ch.last_word = 1'b0;
		rx_level = 0;
		rdy_hold = 0;
		rdy_val = 1'b1;
		quiet_cycles = 0;
		words_sent = 0;
		prints_sent = 0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero threshold, one part
		send_fields('0, '0, '0, '0, '0, ONES, '0, 1'b1);
		send_fields(ONES, '0, '0, '0, '0, ONES, ONES, 1'b1);
		set_screen(1, 1);
		send_fields('0, '0, '0, '0, '0, ONES, '0, 1'b1);
		// part count zero acts as one; exact equality at one half
		set_screen(32768, 0);
		send_fields('0, ONES, '0, '0, '0, ONES, LOW32, 1'b1);
		send_fields(ONES, '0, '0, '0, '0, ONES, LOW32, 1'b1);
		set_screen(32769, 0);
		send_fields(ONES, '0, '0, '0, '0, ONES, LOW32, 1'b1);
		// part count above four acts as four; threshold of exactly one
		set_screen(65536, 7);
		send_fields('0, '0, '0, ONES, '0, ONES, ONES, 1'b1);
		send_fields('0, '0, '0, '0, ONES, '0, '0, 1'b1);
		send_fields('0, '0, ~LOW32, '0, '0, ONES, LOW32, 1'b0);
		send_fields('0, '0, '0, '0, ONES, LOW32, ONES, 1'b1);
		set_screen(65536, 2);
		send_fields('0, '0, ONES, ONES, '0, ONES, '0, 1'b1);
		send_fields('0, ONES, '0, '0, '0, ~LOW32, ONES, 1'b1);
		// threshold above one never passes
		set_screen(17'h1FFFF, 4);
		send_fields(ONES, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1);
		send_fields('0, '0, '0, '0, '0, ONES, '0, 1'b1);
		set_screen(0, 4);
		send_fields(ONES, ONES, ONES, ONES, ONES, '0, '0, 1'b1);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: thr = '0;
				1: thr = CFG_DATA_W'(65536);
				2: thr = 17'h1FFFF;
				default: thr = ($urandom_range(0, 3) == 0)
					? CFG_DATA_W'($urandom_range(65537, 131071))
					: CFG_DATA_W'($urandom_range(0, 65536));
			endcase
			set_screen(thr, CFG_DATA_W'(phase % 8));
			phase_words = 0;
			fp = 0;
			pause_at = $urandom_range(1, 6);
			while (phase_words < PHASE_WORDS) begin
				overlong = ($urandom_range(0, 14) == 0);
				if (overlong)
					n = $urandom_range(DEF_FP_WORDS + 1, DEF_FP_WORDS + 8);
				else if ($urandom_range(0, 9) < 7)
					n = $urandom_range(1, 8);
				else
					n = $urandom_range(9, DEF_FP_WORDS);
				rx_level = (phase == 0) ? 0 : $urandom_range(0, 2);
				if (fp == pause_at)
					settle_block();
				send_fingerprint(n, overlong, (phase == 0) ? 0 : $urandom_range(0, 2));
				phase_words += n;
				fp++;
			end
		end

		settle_block();
		$display("%0d words in %0d fingerprints over %0d register settings",
			words_sent, prints_sent, settings_used);
		$display("%0d scores checked: %0d passing, %0d with saturated union",
			tally.checked, tally.passing, tally.saturated);
		if (tally.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
src/cfts_pkg.sv
src/cfts_if.sv
src/cfts_word_count.sv
src/combined_fingerprint_tanimoto_screen_core.sv
dv/combined_fingerprint_tanimoto_screen_core_tb.sv
